// ===== rtl/lcg_pkg.sv =====
package lcg_pkg;

    localparam int DATA_W  = 32;
    localparam int SHIFT_W = 6;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int IDX_W   = 2;

    // reciprocal of the reset modulus (all ones)
    localparam logic [DATA_W-1:0]  MULT_RST         = DATA_W'(1);
    localparam logic [DATA_W-1:0]  INCR_RST         = '0;
    localparam logic [DATA_W-1:0]  MODULUS_RST      = '1;
    localparam logic [DATA_W-1:0]  SEED_RST         = '0;
    localparam logic [DATA_W-1:0]  RECIP_MAGIC_RST  = 32'h8000_0001;
    localparam logic [SHIFT_W-1:0] RECIP_SHIFT_RST  = SHIFT_W'(PROD_W - 1);

    typedef enum logic [IDX_W-1:0] {
        REG_MULT    = 2'd0,
        REG_INCR    = 2'd1,
        REG_MODULUS = 2'd2,
        REG_SEED    = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_ADD,
        S_MUL_Q,
        S_SHIFT,
        S_MUL_R,
        S_DONE,
        S_DIV,
        S_NORM,
        S_FIX
    } state_t;

endpackage

// ===== rtl/lcg_if.sv =====
interface lcg_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface lcg_value_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/lcg_with_reciprocal_modulo.sv =====
// channel  dir  payload        meaning
// req      in   tick  [0:0]    request one word
// rsp      out  value [31:0]   next reduced state
// cfg      in   cfg_data[31:0] write port, cfg_index selects register
//
// After acceptance a tick runs through one shared 32x32 multiplier
// (mult*state, +incr, magic*x, shift, q*modulus, subtract); the next tick is taken only
// once the word has gone to the output register. A modulus write runs a 64-step
// restoring divider, then up to 32 normalize steps and one fixup, with req.ready low.
// Reset loads the reciprocal of the reset modulus; no sweep is needed.
// A finished word waits in the output register; the next tick is taken meanwhile.
module lcg_with_reciprocal_modulo
    import lcg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lcg_tick_if.sink           req,
    lcg_value_if.source        rsp,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [DATA_W-1:0]  mult_reg, incr_reg, modulus_reg, cur_reg;
    logic [DATA_W-1:0]  recip_magic_reg;
    logic [SHIFT_W-1:0] recip_shift_reg;
    logic [DATA_W-1:0]  x_reg, q_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_value_reg;

    logic [DATA_W-1:0]  rem_reg;
    logic [PROD_W-1:0]  quo_reg;
    logic [SHIFT_W-1:0] div_cnt_reg;
    logic [SHIFT_W-1:0] div_shift_reg;

    logic               in_ready;
    logic [DATA_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic               mod_wr;
    logic               in_take;
    logic               out_free;
    logic [DATA_W:0]    trial;
    logic               trial_ge;
    logic [DATA_W:0]    fix_sum;
    logic [DATA_W-1:0]  result;

    assign mod_wr   = cfg_we && (cfg_reg_t'(cfg_index) == REG_MODULUS) && (cfg_data != '0);
    assign in_take  = req.valid && in_ready && req.tick;
    assign out_free = !out_valid_reg || rsp.ready;
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign trial    = {rem_reg, (div_cnt_reg == SHIFT_W'(PROD_W - 1))};
    assign trial_ge = trial >= {1'b0, modulus_reg};
    assign fix_sum  = {1'b0, quo_reg[DATA_W-1:0]} + (DATA_W+1)'(1);
    assign result   = x_reg - prod_reg[DATA_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                    state_next = S_MUL_X;
            end
            S_MUL_X: state_next = S_ADD;
            S_ADD:   state_next = S_MUL_Q;
            S_MUL_Q: state_next = S_SHIFT;
            S_SHIFT: state_next = S_MUL_R;
            S_MUL_R: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = S_NORM;
            end
            S_NORM:
            begin
                if (quo_reg[PROD_W-1:DATA_W] == '0)
                    state_next = S_FIX;
            end
            S_FIX:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (mod_wr)
            state_next = S_DIV;
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            S_IDLE:  in_ready = !cfg_we;
            S_MUL_X:
            begin
                mul_a = mult_reg;
                mul_b = cur_reg;
            end
            S_MUL_Q:
            begin
                mul_a = recip_magic_reg;
                mul_b = x_reg;
            end
            S_MUL_R:
            begin
                mul_a = q_reg;
                mul_b = modulus_reg;
            end
            default: ;
        endcase
    end

    assign req.ready = in_ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mult_reg        <= MULT_RST;
            incr_reg        <= INCR_RST;
            modulus_reg     <= MODULUS_RST;
            cur_reg         <= SEED_RST;
            recip_magic_reg <= RECIP_MAGIC_RST;
            recip_shift_reg <= RECIP_SHIFT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= result;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_FIX)
            begin
                if (!fix_sum[0])
                begin
                    recip_magic_reg <= fix_sum[DATA_W:1];
                    recip_shift_reg <= div_shift_reg - SHIFT_W'(1);
                end
                else
                begin
                    recip_magic_reg <= fix_sum[DATA_W-1:0];
                    recip_shift_reg <= div_shift_reg;
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MULT: mult_reg <= cfg_data;
                    REG_INCR: incr_reg <= cfg_data;
                    REG_MODULUS:
                    begin
                        if (cfg_data != '0)
                            modulus_reg <= cfg_data;
                    end
                    REG_SEED: cur_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath and divider, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
            out_value_reg <= result;
        case (state_reg)
            S_MUL_X, S_MUL_Q, S_MUL_R: prod_reg <= mul_p;
            S_ADD:   x_reg <= prod_reg[DATA_W-1:0] + incr_reg;
            S_SHIFT: q_reg <= DATA_W'(prod_reg >> recip_shift_reg);
            S_DIV:
            begin
                rem_reg     <= trial_ge ? DATA_W'(trial - {1'b0, modulus_reg})
                                        : trial[DATA_W-1:0];
                quo_reg     <= {quo_reg[PROD_W-2:0], trial_ge};
                div_cnt_reg <= div_cnt_reg - SHIFT_W'(1);
            end
            S_NORM:
            begin
                if (quo_reg[PROD_W-1:DATA_W] != '0)
                begin
                    quo_reg       <= quo_reg >> 1;
                    div_shift_reg <= div_shift_reg - SHIFT_W'(1);
                end
            end
            default: ;
        endcase
        if (mod_wr)
        begin
            rem_reg       <= '0;
            quo_reg       <= '0;
            div_cnt_reg   <= SHIFT_W'(PROD_W - 1);
            div_shift_reg <= SHIFT_W'(PROD_W - 1);
        end
    end

    a_modulus_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        modulus_reg != '0)
        else $error("modulus register holds zero");

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < modulus_reg)
        else $error("divider remainder not below modulus");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.tick) |=> state_reg == S_MUL_X)
        else $error("accepted tick did not start a step");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp.valid && !rsp.ready) |=>
            (state_reg == S_DONE && $stable(rsp.value)))
        else $error("pending word overwritten");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import lcg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 120;
    localparam int PHASES        = 10;
    localparam int WORDS_PER_PH  = 70;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TICK,
        ROW_IDLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_reg_t          idx;
        logic [DATA_W-1:0] data;
        logic              has_exp;
        logic [DATA_W-1:0] exp;
    } stim_row_t;

    localparam int N_PLAN = 37;
    localparam stim_row_t PLAN [N_PLAN] = '{
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_IDLE, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_CFG,  REG_SEED,    32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b1, 32'hFFFF_FFFE},
        '{ROW_CFG,  REG_SEED,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_CFG,  REG_MULT,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_INCR,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_SEED,    32'h1234_5678, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        // zero modulus is dropped
        '{ROW_CFG,  REG_MODULUS, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MODULUS, 32'h0000_0001, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_IDLE, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_INCR,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MODULUS, 32'h0000_0002, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_CFG,  REG_INCR,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MODULUS, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MODULUS, 32'h8000_0001, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MULT,    32'h0019_660D, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_INCR,    32'h3C6E_F35F, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_SEED,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MODULUS, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_CFG,  REG_MODULUS, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_TICK, REG_MULT,    32'h0000_0000, 1'b0, 32'h0000_0000}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;

    lcg_tick_if  req_if ();
    lcg_value_if rsp_if ();

    lcg_with_reciprocal_modulo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the generator
    logic [DATA_W-1:0]  gen_mult;
    logic [DATA_W-1:0]  gen_incr;
    logic [DATA_W-1:0]  gen_modulus;
    logic [DATA_W-1:0]  gen_magic;
    logic [SHIFT_W-1:0] gen_shift;
    logic [DATA_W-1:0]  gen_state;

    logic [DATA_W-1:0] pending_values [$];
    int unsigned       fails;
    bit                steady;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic void load_modulus(input logic [DATA_W-1:0] m);
        logic [PROD_W-1:0] mg;
        int unsigned       sh;
        if (m == '0)
            return;
        sh = PROD_W - 1;
        mg = (64'd1 << (PROD_W - 1)) / {32'd0, m};
        while (mg >= 64'h1_0000_0000)
        begin
            mg = mg >> 1;
            sh--;
        end
        mg = mg + 64'd1;
        if (!mg[0])
        begin
            mg = mg >> 1;
            sh--;
        end
        gen_modulus = m;
        gen_magic   = mg[DATA_W-1:0];
        gen_shift   = sh[SHIFT_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] lcg_next();
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] q;
        logic [PROD_W-1:0] prod;
        x         = gen_mult * gen_state + gen_incr;
        prod      = {32'd0, gen_magic} * {32'd0, x};
        q         = prod[DATA_W-1:0];
        q         = DATA_W'(prod >> gen_shift);
        gen_state = x - q * gen_modulus;
        return gen_state;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return DATA_W'($urandom_range(16));
            3: return 32'h8000_0000 >> $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    task automatic report(input string msg);
        fails++;
        if (fails <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // block must be idle: nothing pending, then room for a divider run
    task automatic settle();
        req_if.valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_MULT:    gen_mult = data;
            REG_INCR:    gen_incr = data;
            REG_MODULUS: load_modulus(data);
            REG_SEED:    gen_state = data;
            default:     ;
        endcase
    endtask

    task automatic push_tick(input logic t, input logic typed, input logic [DATA_W-1:0] typed_val);
        logic [DATA_W-1:0] predicted;
        cfg_we <= 1'b0;
        if (!steady && $urandom_range(99) < 19)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.tick  <= t;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (t)
        begin
            predicted = lcg_next();
            pending_values.push_back(typed ? typed_val : predicted);
        end
    endtask

    // result side
    initial
    begin
        logic [DATA_W-1:0] want;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                if (pending_values.size() == 0)
                    report($sformatf("unexpected word %h", rsp_if.value));
                else
                begin
                    want = pending_values.pop_front();
                    if (rsp_if.value !== want)
                        report($sformatf("value: expected %h got %h", want, rsp_if.value));
                end
            end
            rsp_if.ready <= steady || ($urandom_range(99) >= 19);
        end
    end

    initial
    begin
        fails        = 0;
        steady       = 1'b0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        req_if.valid <= 1'b0;
        req_if.tick  <= 1'b0;

        gen_mult  = MULT_RST;
        gen_incr  = INCR_RST;
        gen_state = SEED_RST;
        load_modulus(MODULUS_RST);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PLAN; i++)
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                if (i == 0 || PLAN[(i == 0) ? 0 : i - 1].kind != ROW_CFG)
                    settle();
                write_reg(PLAN[i].idx, PLAN[i].data);
            end
            else
                push_tick(PLAN[i].kind == ROW_TICK, PLAN[i].has_exp, PLAN[i].exp);
        end

        // modulus goes last so the divider run overlaps the stalled ticks
        for (int ph = 0; ph < PHASES; ph++)
        begin
            steady = (ph == 4 || ph == 5);
            settle();
            if ($urandom_range(9) < 7)
                write_reg(REG_MULT, rand_word());
            if ($urandom_range(9) < 7)
                write_reg(REG_INCR, rand_word());
            if ($urandom_range(9) < 5)
                write_reg(REG_SEED, rand_word());
            if ($urandom_range(9) < 8)
                write_reg(REG_MODULUS, rand_word());
            for (int n = 0; n < WORDS_PER_PH; n++)
                push_tick($urandom_range(9) != 0, 1'b0, '0);
        end

        req_if.valid <= 1'b0;
        for (int k = 0; k < 20000 && pending_values.size() != 0; k++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_values.size() != 0)
            report($sformatf("%0d words never arrived", pending_values.size()));

        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lcg_pkg.sv
rtl/lcg_if.sv
rtl/lcg_with_reciprocal_modulo.sv
dv/tb_top.sv
